[hdl/ocl_pkg.sv]
// ----------------------------------------------------------------------------
// ocl_pkg: shared types and constants for the order command line parser
// Request/response payloads, the front-to-back queue entry, and keyword text.
// ----------------------------------------------------------------------------
package ocl_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic [1:0]         command_kind;
      logic [2:0]         error_code;
      logic [63:0]        order_id;
      logic               side_sell;
      logic signed [63:0] limit_price;
      logic [63:0]        order_quantity;
   } rsp_type;

   // classified byte handed from the front to the back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_line;
      logic       is_space;
      logic       is_digit;
      logic [3:0] digit;
   } cls_type;

   localparam logic [1:0] CMD_CANCEL = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_MARKET = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [2:0] ERR_OK    = 3'd0;
   localparam logic [2:0] ERR_EMPTY = 3'd1;
   localparam logic [2:0] ERR_CMD   = 3'd2;
   localparam logic [2:0] ERR_COUNT = 3'd3;
   localparam logic [2:0] ERR_ID    = 3'd4;
   localparam logic [2:0] ERR_SIDE  = 3'd5;
   localparam logic [2:0] ERR_PRICE = 3'd6;
   localparam logic [2:0] ERR_QTY   = 3'd7;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // keyword character at a position, zero past the end
   function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] pos);
      logic [47:0] txt;
      txt = 48'h0;
      case (kw)
         2'd0:    txt = "CANCEL";
         2'd1:    txt = {"ADD", 24'h0};
         2'd2:    txt = "MARKET";
         default: txt = 48'h0;
      endcase
      kw_char = (pos > 3'd5) ? 8'h0 : txt[8'(47 - 8 * 32'(pos)) -: 8];
   endfunction

   function automatic logic [7:0] side_char(input logic sd, input logic [2:0] pos);
      logic [31:0] txt;
      txt = sd ? "SELL" : {"BUY", 8'h0};
      side_char = (pos > 3'd3) ? 8'h0 : txt[6'(31 - 8 * 32'(pos)) -: 8];
   endfunction

endpackage

[hdl/ocl_front.sv]
// ----------------------------------------------------------------------------
// ocl_front: byte intake and classification
// Accepts request bytes, tags separators and digits, pushes into a 2-entry queue.
// ----------------------------------------------------------------------------
module ocl_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ocl_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_ready,
   output ocl_pkg::cls_type q_data
);

   ocl_pkg::cls_type cls;
   ocl_pkg::cls_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   always_comb begin
      cls.data_byte   = req_data.data_byte;
      cls.end_of_line = req_data.end_of_line;
      cls.is_space    = req_data.data_byte == ocl_pkg::CH_SPACE ||
                        req_data.data_byte == ocl_pkg::CH_TAB ||
                        req_data.data_byte == ocl_pkg::CH_CR ||
                        req_data.data_byte == ocl_pkg::CH_LF;
      cls.is_digit    = req_data.data_byte >= ocl_pkg::CH_ZERO &&
                        req_data.data_byte <= ocl_pkg::CH_NINE;
      cls.digit       = 4'(req_data.data_byte - ocl_pkg::CH_ZERO);
   end

   assign req_ready = cnt_ff != 2'd2;
   assign q_valid   = cnt_ff != 2'd0;
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;
   assign q_data    = mem_ff[rd_ptr_ff];
   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[hdl/ocl_back.sv]
// ----------------------------------------------------------------------------
// ocl_back: token parser and response register
// Consumes classified bytes, tracks tokens and fields, emits one response per line.
// ----------------------------------------------------------------------------
module ocl_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  ocl_pkg::cls_type q_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ocl_pkg::rsp_type rsp_data
);

   logic [2:0]  tok_ff, tok_in;
   logic        intok_ff, intok_in;
   logic [2:0]  cidx_ff, cidx_in;
   logic [2:0]  kwc_ff, kwc_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [1:0]  sdc_ff, sdc_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  nf_ff, nf_in;    // digit, bad, minus, overflow
   logic [3:0]  fv_ff, fv_in;    // id, side, price, qty
   logic [63:0] id_ff, id_in, pr_ff, pr_in, qt_ff, qt_in;
   logic        sd_ff, sd_in;
   logic        rv_ff, rv_in;
   ocl_pkg::rsp_type rsp_ff, rsp_in;

   logic        step;
   logic [2:0]  t;
   logic        sgnf;
   logic [63:0] acc_x10;
   logic [64:0] acc_sum;
   logic        ovf;
   logic [63:0] lim;
   logic [2:0]  need;
   logic [2:0]  err;
   logic [1:0]  kind;

   assign q_ready   = !rv_ff || rsp_ready;
   assign step      = q_valid && q_ready;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // x10 by a 68-bit multiply; overflow if product or sum exceeds 64 bits
   always_comb begin
      logic [67:0] p;
      p       = {4'h0, acc_ff} * 68'd10;
      acc_x10 = p[63:0];
      acc_sum = {1'b0, acc_x10} + {61'h0, q_data.digit};
      ovf     = (p[67:64] != 4'h0) || acc_sum[64];
   end

   always_comb begin
      logic [2:0] tk;
      logic       in_t;
      logic [2:0] ci;
      logic [1:0] sc;
      logic [63:0] ac;
      logic [3:0] nf;
      logic [2:0] kc;
      tok_in = tok_ff; intok_in = intok_ff; cidx_in = cidx_ff; kwc_in = kwc_ff;
      cmd_in = cmd_ff; sdc_in = sdc_ff; acc_in = acc_ff; nf_in = nf_ff; fv_in = fv_ff;
      id_in = id_ff; sd_in = sd_ff; pr_in = pr_ff; qt_in = qt_ff;
      rv_in = rv_ff && !rsp_ready; rsp_in = rsp_ff;
      t = 3'd0; sgnf = 1'b0; lim = 64'h0; need = 3'd0; err = ocl_pkg::ERR_OK;
      kind = ocl_pkg::CMD_NONE;
      tk = tok_ff; in_t = intok_ff; ci = cidx_ff; sc = sdc_ff; ac = acc_ff; nf = nf_ff;
      kc = kwc_ff;
      if (step) begin
         if (!q_data.is_space) begin
            if (!intok_ff) begin
               in_t = 1'b1;
               if (tk != 3'd7) tk = tk + 3'd1;
               ci = 3'd0; sc = 2'b11; ac = 64'h0; nf = 4'h0;
            end
            t    = tk - 3'd1;
            sgnf = (t == 3'd3) && (cmd_in == ocl_pkg::CMD_ADD);
            if (t == 3'd0) begin
               for (int i = 0; i < 3; i++) begin
                  if (ocl_pkg::kw_char(2'(i), ci) != q_data.data_byte) kc[i] = 1'b0;
               end
            end else if (t == 3'd2) begin
               for (int i = 0; i < 2; i++) begin
                  if (ocl_pkg::side_char(1'(i), ci) != q_data.data_byte) sc[i] = 1'b0;
               end
            end else if (t == 3'd1 || t == 3'd3 || t == 3'd4) begin
               if (q_data.is_digit) begin
                  nf[0] = 1'b1;
                  // fresh token starts from zero, so overflow cannot occur then
                  if (intok_ff && ovf) nf[3] = 1'b1;
                  else if (intok_ff) ac = acc_sum[63:0];
                  else ac = {60'h0, q_data.digit};
               end else if (q_data.data_byte == ocl_pkg::CH_MINUS && sgnf && ci == 3'd0) begin
                  nf[2] = 1'b1;
               end else begin
                  nf[1] = 1'b1;
               end
            end
            if (ci != 3'd7) ci = ci + 3'd1;
         end
         // token end on separator, or on end of line while inside a token
         if (in_t && (q_data.is_space || q_data.end_of_line)) begin
            in_t = 1'b0;
            t    = tk - 3'd1;
            if (t == 3'd0) begin
               cmd_in = ocl_pkg::CMD_NONE;
               if (kc[0] && ci == 3'd6) cmd_in = ocl_pkg::CMD_CANCEL;
               else if (kc[1] && ci == 3'd3) cmd_in = ocl_pkg::CMD_ADD;
               else if (kc[2] && ci == 3'd6) cmd_in = ocl_pkg::CMD_MARKET;
            end else if (t == 3'd1) begin
               if (nf == 4'b0001) begin fv_in[0] = 1'b1; id_in = ac; end
            end else if (t == 3'd2) begin
               if (sc[0] && ci == 3'd3) begin fv_in[1] = 1'b1; sd_in = 1'b0; end
               if (sc[1] && ci == 3'd4) begin fv_in[1] = 1'b1; sd_in = 1'b1; end
            end else if (t == 3'd3 && cmd_in == ocl_pkg::CMD_ADD) begin
               lim = nf[2] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
               if (nf[0] && !nf[1] && !nf[3] && ac <= lim) begin
                  fv_in[2] = 1'b1;
                  pr_in    = nf[2] ? 64'h0 - ac : ac;
               end
            end else if (t == 3'd3 || t == 3'd4) begin
               if (nf == 4'b0001) begin fv_in[3] = 1'b1; qt_in = ac; end
            end
         end
         tok_in = tk; intok_in = in_t; cidx_in = ci; sdc_in = sc; acc_in = ac;
         nf_in = nf; kwc_in = kc;
         if (q_data.end_of_line) begin
            kind = cmd_in;
            need = (kind == ocl_pkg::CMD_CANCEL) ? 3'd2 :
                   (kind == ocl_pkg::CMD_ADD) ? 3'd5 : 3'd4;
            if (tk == 3'd0) begin kind = ocl_pkg::CMD_NONE; err = ocl_pkg::ERR_EMPTY; end
            else if (kind == ocl_pkg::CMD_NONE) err = ocl_pkg::ERR_CMD;
            else if (tk != need) err = ocl_pkg::ERR_COUNT;
            else if (!fv_in[0]) err = ocl_pkg::ERR_ID;
            else if (kind != ocl_pkg::CMD_CANCEL && !fv_in[1]) err = ocl_pkg::ERR_SIDE;
            else if (kind == ocl_pkg::CMD_ADD && !fv_in[2]) err = ocl_pkg::ERR_PRICE;
            else if (kind != ocl_pkg::CMD_CANCEL && !fv_in[3]) err = ocl_pkg::ERR_QTY;
            rv_in = 1'b1;
            rsp_in.command_kind   = kind;
            rsp_in.error_code     = err;
            rsp_in.order_id       = (err == ocl_pkg::ERR_OK) ? id_in : 64'h0;
            rsp_in.side_sell      = (err == ocl_pkg::ERR_OK && kind != ocl_pkg::CMD_CANCEL)
                                    ? sd_in : 1'b0;
            rsp_in.limit_price    = (err == ocl_pkg::ERR_OK && kind == ocl_pkg::CMD_ADD)
                                    ? pr_in : 64'h0;
            rsp_in.order_quantity = (err == ocl_pkg::ERR_OK && kind != ocl_pkg::CMD_CANCEL)
                                    ? qt_in : 64'h0;
            tok_in = 3'd0; intok_in = 1'b0; cidx_in = 3'd0; kwc_in = 3'b111;
            cmd_in = ocl_pkg::CMD_NONE; sdc_in = 2'b11; acc_in = 64'h0; nf_in = 4'h0;
            fv_in = 4'h0; id_in = 64'h0; sd_in = 1'b0; pr_in = 64'h0; qt_in = 64'h0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      acc_ff <= acc_in;
      id_ff  <= id_in;
      pr_ff  <= pr_in;
      qt_ff  <= qt_in;
      sd_ff  <= sd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 3'd0; intok_ff <= 1'b0; cidx_ff <= 3'd0; kwc_ff <= 3'b111;
         cmd_ff <= ocl_pkg::CMD_NONE; sdc_ff <= 2'b11; nf_ff <= 4'h0; fv_ff <= 4'h0;
         rv_ff  <= 1'b0;
      end else begin
         tok_ff <= tok_in; intok_ff <= intok_in; cidx_ff <= cidx_in; kwc_ff <= kwc_in;
         cmd_ff <= cmd_in; sdc_ff <= sdc_in; nf_ff <= nf_in; fv_ff <= fv_in;
         rv_ff  <= rv_in;
      end
   end

endmodule

[hdl/order_command_line_parser_unit.sv]
// ----------------------------------------------------------------------------
// order_command_line_parser_unit: byte-stream order command decoder
// Turns a CANCEL/ADD/MARKET text line into one decoded order or error code.
// ----------------------------------------------------------------------------
// One request byte is taken per cycle, back to back, as long as responses are
// drained. A byte is first registered in the front's two-entry queue, then
// parsed by the back as it leaves the queue. The back parses one byte per cycle
// (a x10-and-add on the 64-bit accumulator is its longest path) and holds the
// response in an output register. The back takes a new byte while no response
// waits or in the cycle the waiting one is taken; while a response sits unread
// the back stalls, the queue fills and req_ready drops. Only end-of-line bytes
// produce a response.
module order_command_line_parser_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ocl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ocl_pkg::rsp_type rsp_data
);

   logic             q_valid, q_ready;
   ocl_pkg::cls_type q_data;

   // front: intake and classify
   ocl_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_ready, .q_data
   );

   // back: token parse and response
   ocl_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   // empty and unknown-command results never carry a command kind
   a_kind_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.error_code == ocl_pkg::ERR_EMPTY ||
                    rsp_data.error_code == ocl_pkg::ERR_CMD)
      |-> rsp_data.command_kind == ocl_pkg::CMD_NONE)
      else $error("error result with command kind");

   // errored results carry zero order id and order quantity
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ocl_pkg::ERR_OK
      |-> rsp_data.order_id == 64'h0 && rsp_data.order_quantity == 64'h0)
      else $error("payload on error");

   // a response appears only after a consumed end-of-line byte
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_valid && q_ready && q_data.end_of_line))
      else $error("response without end of line");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for the order command line parser
// Sends command lines byte by byte, predicts each decoded order, and checks
// every response field against it under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   ocl_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   ocl_pkg::rsp_type rsp_data;

   order_command_line_parser_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   localparam int CYCLE_LIMIT = 400000;

   // parser state mirrored in the predictor
   int unsigned   p_tokens;
   bit            p_in_token;
   int unsigned   p_pos;
   bit [2:0]      p_kw_hits;
   logic [1:0]    p_cmd;
   bit [1:0]      p_side_hits;
   bit [63:0]     p_acc;
   bit            p_digit, p_bad, p_neg, p_ovf;
   bit            p_id_ok, p_side_ok, p_price_ok, p_qty_ok;
   bit [63:0]     p_id, p_price, p_qty;
   bit            p_sell;

   ocl_pkg::rsp_type expected_orders[$];
   int            fail_count;
   int            cycle_count;
   bit            quiet_tail;   // no idling in the closing stretch

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      fail_count++;
   endtask

   function automatic void parser_clear();
      p_tokens = 0; p_in_token = 0; p_pos = 0; p_kw_hits = 3'b111;
      p_cmd = ocl_pkg::CMD_NONE;
      p_side_hits = 2'b11; p_acc = 0;
      {p_digit, p_bad, p_neg, p_ovf} = 0;
      {p_id_ok, p_side_ok, p_price_ok, p_qty_ok} = 0;
      p_id = 0; p_price = 0; p_qty = 0; p_sell = 0;
   endfunction

   function automatic byte unsigned keyword_at(int k, int i);
      string s;
      s = (k == 0) ? "CANCEL" : (k == 1) ? "ADD" : "MARKET";
      return (i < s.len()) ? s[i] : 8'h00;
   endfunction

   function automatic int keyword_len(int k);
      return (k == 1) ? 3 : 6;
   endfunction

   function automatic void token_close();
      int unsigned t;
      bit [63:0]   lim;
      t = p_tokens - 1;
      p_in_token = 0;
      if (t == 0) begin
         p_cmd = ocl_pkg::CMD_NONE;
         for (int k = 2; k >= 0; k--)
            if (p_kw_hits[k] && p_pos == keyword_len(k)) p_cmd = k[1:0];
      end else if (t == 1) begin
         if (p_digit && !p_bad && !p_neg && !p_ovf) begin
            p_id_ok = 1; p_id = p_acc;
         end
      end else if (t == 2) begin
         // BUY is three letters, SELL four
         if (p_side_hits[0] && p_pos == 3) begin
            p_side_ok = 1; p_sell = 0;
         end
         if (p_side_hits[1] && p_pos == 4) begin
            p_side_ok = 1; p_sell = 1;
         end
      end else if (t == 3 && p_cmd == ocl_pkg::CMD_ADD) begin
         lim = p_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         if (p_digit && !p_bad && !p_ovf && p_acc <= lim) begin
            p_price_ok = 1;
            p_price = p_neg ? -p_acc : p_acc;
         end
      end else if (t == 3 || t == 4) begin
         if (p_digit && !p_bad && !p_neg && !p_ovf) begin
            p_qty_ok = 1; p_qty = p_acc;
         end
      end
   endfunction

   function automatic void token_byte(byte unsigned c);
      int unsigned t;
      bit [63:0]   d;
      string       sd;
      t = p_tokens - 1;
      if (t == 0) begin
         for (int k = 0; k < 3; k++)
            if (p_pos >= keyword_len(k) || keyword_at(k, p_pos) != c) p_kw_hits[k] = 0;
      end else if (t == 2) begin
         for (int k = 0; k < 2; k++) begin
            sd = k ? "SELL" : "BUY";
            if (p_pos >= sd.len() || sd[p_pos] != c) p_side_hits[k] = 0;
         end
      end else if (t == 1 || t == 3 || t == 4) begin
         if (c >= ocl_pkg::CH_ZERO && c <= ocl_pkg::CH_NINE) begin
            d = c - ocl_pkg::CH_ZERO;
            p_digit = 1;
            if (p_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) p_ovf = 1;
            else p_acc = p_acc * 10 + d;
         end else if (c == ocl_pkg::CH_MINUS && t == 3 && p_cmd == ocl_pkg::CMD_ADD &&
                      p_pos == 0) begin
            p_neg = 1;
         end else begin
            p_bad = 1;
         end
      end
      if (p_pos < 7) p_pos++;
   endfunction

   // predicts the decoded order for one request byte
   function automatic void predict_order(byte unsigned c, bit eol);
      ocl_pkg::rsp_type r;
      int unsigned      need;
      if (c == ocl_pkg::CH_SPACE || c == ocl_pkg::CH_TAB || c == ocl_pkg::CH_CR ||
          c == ocl_pkg::CH_LF) begin
         if (p_in_token) token_close();
      end else begin
         if (!p_in_token) begin
            p_in_token = 1;
            if (p_tokens < 7) p_tokens++;
            p_pos = 0; p_side_hits = 2'b11; p_acc = 0;
            {p_digit, p_bad, p_neg, p_ovf} = 0;
         end
         token_byte(c);
      end
      if (!eol) return;
      if (p_in_token) token_close();
      r = '0;
      r.command_kind = p_cmd;
      need = (p_cmd == ocl_pkg::CMD_CANCEL) ? 2 : (p_cmd == ocl_pkg::CMD_ADD) ? 5 : 4;
      if (p_tokens == 0) begin
         r.command_kind = ocl_pkg::CMD_NONE; r.error_code = ocl_pkg::ERR_EMPTY;
      end else if (p_cmd == ocl_pkg::CMD_NONE) r.error_code = ocl_pkg::ERR_CMD;
      else if (p_tokens != need) r.error_code = ocl_pkg::ERR_COUNT;
      else if (!p_id_ok) r.error_code = ocl_pkg::ERR_ID;
      else if (p_cmd != ocl_pkg::CMD_CANCEL && !p_side_ok) r.error_code = ocl_pkg::ERR_SIDE;
      else if (p_cmd == ocl_pkg::CMD_ADD && !p_price_ok) r.error_code = ocl_pkg::ERR_PRICE;
      else if (p_cmd != ocl_pkg::CMD_CANCEL && !p_qty_ok) r.error_code = ocl_pkg::ERR_QTY;
      else r.error_code = ocl_pkg::ERR_OK;
      if (r.error_code == ocl_pkg::ERR_OK) begin
         r.order_id = p_id;
         if (p_cmd != ocl_pkg::CMD_CANCEL) begin
            r.side_sell = p_sell; r.order_quantity = p_qty;
         end
         if (p_cmd == ocl_pkg::CMD_ADD) r.limit_price = p_price;
      end
      expected_orders.insert(expected_orders.size(), r);
      parser_clear();
   endfunction

   // sends one request byte, with an occasional idle burst ahead of it
   task automatic send_byte(byte unsigned c, bit eol);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: c, end_of_line: eol};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_order(c, eol);
   endtask

   task automatic send_line(string s);
      if (s.len() == 0) begin
         send_byte(ocl_pkg::CH_LF, 1);
         return;
      end
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // response side: random stall bursts, checks on each accepted response
   initial begin
      int stall;
      ocl_pkg::rsp_type e;
      rsp_ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_orders.size() == 0) report_mismatch("response with none expected");
            else begin
               e = expected_orders.pop_front();
               if (rsp_data.command_kind != e.command_kind)
                  report_mismatch($sformatf("kind %0d exp %0d", rsp_data.command_kind,
                                            e.command_kind));
               if (rsp_data.error_code != e.error_code)
                  report_mismatch($sformatf("error %0d exp %0d", rsp_data.error_code,
                                            e.error_code));
               if (rsp_data.order_id != e.order_id)
                  report_mismatch($sformatf("id %0d exp %0d", rsp_data.order_id, e.order_id));
               if (rsp_data.side_sell != e.side_sell)
                  report_mismatch($sformatf("side %0d exp %0d", rsp_data.side_sell,
                                            e.side_sell));
               if (rsp_data.limit_price != e.limit_price)
                  report_mismatch($sformatf("price %0d exp %0d", rsp_data.limit_price,
                                            e.limit_price));
               if (rsp_data.order_quantity != e.order_quantity)
                  report_mismatch($sformatf("qty %0d exp %0d", rsp_data.order_quantity,
                                            e.order_quantity));
            end
         end
         if (stall > 0 && !quiet_tail) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            // this cycle stalls too, on top of the drawn remaining count
            stall = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic string rand_digits(int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++)
         s = {s, string'(byte'(ocl_pkg::CH_ZERO + $urandom_range(0, 9)))};
      return s;
   endfunction

   function automatic string rand_number(bit allow_minus);
      string s;
      int    pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) s = "18446744073709551615";
      else if (pick == 1) s = "18446744073709551616";
      else if (pick == 2) s = "9223372036854775807";
      else if (pick == 3) s = "9223372036854775808";
      else if (pick == 4) s = rand_digits($urandom_range(19, 22));
      else if (pick == 5) s = "0";
      else if (pick == 6) s = {rand_digits($urandom_range(1, 3)), "x"};
      else s = rand_digits($urandom_range(1, 8));
      if (allow_minus && $urandom_range(0, 3) == 0) s = {"-", s};
      return s;
   endfunction

   function automatic string rand_sep();
      case ($urandom_range(0, 5))
         0: return "\t";
         1: return "  ";
         2: return " \r";
         default: return " ";
      endcase
   endfunction

   function automatic string rand_token();
      string s;
      s = "";
      for (int i = $urandom_range(1, 9); i > 0; i--)
         s = {s, string'(byte'($urandom_range(33, 126)))};
      return s;
   endfunction

   task automatic test_directed_lines();
      send_line("CANCEL 42");
      send_line("ADD 7 BUY -9223372036854775808 18446744073709551615");
      send_line("ADD 18446744073709551615 SELL 9223372036854775807 1");
      send_line("MARKET 0 SELL 0");
      send_line("");                                    // blank line
      send_line("  \t\r");                              // whitespace only
      send_line("cancel 1");                            // case matters
      send_line("CANCELX 1");
      send_line("ADD 1 BUY 5");                          // too few tokens
      send_line("CANCEL 1 2 3 4 5 6 7 8");               // saturated count
      send_line("CANCEL 18446744073709551616");          // id overflow
      send_line("MARKET 1 BUYS 3");
      send_line("ADD 1 SELL 9223372036854775808 3");     // price out of range
      send_line("ADD 1 BUY - 3");                        // lone minus
      send_line("ADD 1 BUY +5 3");
      send_line("MARKET 1 BUY -3");                      // minus not allowed here
      send_line("ADD 1 BUY 5 1x");
      send_line("\tMARKET\t9 SELL 12\n");
      // control and high bytes inside tokens
      send_byte(8'h00, 0);
      send_byte(8'hFF, 1);
      send_byte(8'h80, 0);
      send_byte(ocl_pkg::CH_SPACE, 1);
      drop_valid();
   endtask

   task automatic test_random_lines(int count);
      string s;
      int    k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 9);
         if (k <= 1) s = {"CANCEL", rand_sep(), rand_number(0)};
         else if (k <= 4)
            s = {"ADD", rand_sep(), rand_number(0), rand_sep(),
                 ($urandom_range(0, 1) ? "SELL" : "BUY"), rand_sep(), rand_number(1),
                 rand_sep(), rand_number(0)};
         else if (k <= 6)
            s = {"MARKET", rand_sep(), rand_number(0), rand_sep(),
                 ($urandom_range(0, 1) ? "SELL" : "BUY"), rand_sep(), rand_number(0)};
         else begin
            s = "";
            for (int i = $urandom_range(0, 7); i > 0; i--) s = {s, rand_token(), rand_sep()};
         end
         if ($urandom_range(0, 4) == 0) s = {rand_sep(), s};
         if ($urandom_range(0, 4) == 0) s = {s, rand_sep()};
         send_line(s);
      end
   endtask

   // raw bytes, any value, end of line now and then
   task automatic test_random_bytes(int count);
      for (int n = 0; n < count; n++)
         send_byte(8'($urandom_range(0, 255)), n == count - 1 || $urandom_range(0, 15) == 0);
   endtask

   initial begin
      fail_count   = 0;
      quiet_tail   = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      parser_clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_lines();
      test_random_lines(40);
      test_random_bytes(250);
      quiet_tail = 1;
      test_random_lines(15);
      drop_valid();
      while (expected_orders.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
